### design/sfr_pkg.sv
// Shared types and constants for the sensor frame receiver.
// No dependencies; used by sfr_parser and sensor_frame_receiver.
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int PAYLOAD_W = 48;
	localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;

	// register reset values
	localparam logic [7:0] HEADER_RESET   = 8'h5a;
	localparam logic [7:0] FUNCTION_RESET = 8'h45;

	// register indexes, taken from paddr[2]
	localparam logic REG_HEADER   = 1'b0;
	localparam logic REG_FUNCTION = 1'b1;

	// hunt positions; POS_PAYLOAD + k once k payload bytes are in
	localparam logic [3:0] POS_HDR0    = 4'd0;
	localparam logic [3:0] POS_HDR1    = 4'd1;
	localparam logic [3:0] POS_FUNC    = 4'd2;
	localparam logic [3:0] POS_LEN     = 4'd3;
	localparam logic [3:0] POS_PAYLOAD = 4'd4;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [2:0]           payload_len;
		logic                 checksum_ok;
		logic [7:0]           frame_function;
	} frame_result_t;

endpackage

### design/sfr_parser.sv
// Frame hunt state, running checksum and payload store.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_parser #(
	parameter int MAX_PAYLOAD = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  restart,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            header_byte,
	input  logic [7:0]            function_code,
	output logic                  res_valid,
	output sfr_pkg::frame_result_t res
);

	localparam int LenW  = $clog2(MAX_PAYLOAD + 1);
	localparam int NShow = (MAX_PAYLOAD < sfr_pkg::PAYLOAD_BYTES) ? MAX_PAYLOAD
		: sfr_pkg::PAYLOAD_BYTES;

	logic [3:0]      pos_q, pos_d;
	logic [LenW-1:0] len_q, len_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      store_q [MAX_PAYLOAD];
	logic [3:0]      k;
	logic            store_we;
	logic [7:0]      sum_add;

	assign k       = pos_q - sfr_pkg::POS_PAYLOAD;
	assign sum_add = sum_q + rx_byte;

	always_comb begin
		pos_d     = pos_q;
		len_d     = len_q;
		sum_d     = sum_q;
		store_we  = 1'b0;
		res_valid = 1'b0;
		unique case (pos_q)
			sfr_pkg::POS_HDR0: begin
				if (rx_byte == header_byte) begin
					sum_d = rx_byte;
					pos_d = sfr_pkg::POS_HDR1;
				end
			end
			sfr_pkg::POS_HDR1: begin
				if (rx_byte == header_byte) begin
					sum_d = sum_add;
					pos_d = sfr_pkg::POS_FUNC;
				end else begin
					pos_d = sfr_pkg::POS_HDR0;
					len_d = '0;
					sum_d = '0;
				end
			end
			sfr_pkg::POS_FUNC: begin
				if (rx_byte == function_code) begin
					sum_d = sum_add;
					pos_d = sfr_pkg::POS_LEN;
				end else begin
					pos_d = sfr_pkg::POS_HDR0;
					len_d = '0;
					sum_d = '0;
				end
			end
			sfr_pkg::POS_LEN: begin
				if (rx_byte > 8'(MAX_PAYLOAD)) begin
					pos_d = sfr_pkg::POS_HDR0;
					len_d = '0;
					sum_d = '0;
				end else begin
					len_d = LenW'(rx_byte);
					sum_d = sum_add;
					pos_d = sfr_pkg::POS_PAYLOAD;
				end
			end
			default: begin
				if (k > 4'(MAX_PAYLOAD)) begin
					pos_d = sfr_pkg::POS_HDR0;
					len_d = '0;
					sum_d = '0;
				end else if (k < 4'(len_q)) begin
					store_we = 1'b1;
					sum_d    = sum_add;
					pos_d    = pos_q + 4'd1;
				end else begin
					// checksum byte: frame done, start over
					res_valid = 1'b1;
					pos_d     = sfr_pkg::POS_HDR0;
					len_d     = '0;
					sum_d     = '0;
				end
			end
		endcase
	end

	always_comb begin
		res.payload = '0;
		for (int i = 0; i < NShow; i++) begin
			if (LenW'(i) < len_q) begin
				res.payload[sfr_pkg::PAYLOAD_W-1-8*i -: 8] = store_q[i];
			end
		end
		res.payload_len    = 3'(len_q);
		res.checksum_ok    = (rx_byte == sum_q);
		res.frame_function = res.checksum_ok ? function_code : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= sfr_pkg::POS_HDR0;
			len_q <= '0;
			sum_q <= '0;
		end else if (restart) begin
			pos_q <= sfr_pkg::POS_HDR0;
			len_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			pos_q <= pos_d;
			len_q <= len_d;
			sum_q <= sum_d;
		end
	end

	// entries past the current length are never read
	always_ff @(posedge clk) begin
		if (accept && store_we && !restart) begin
			for (int i = 0; i < MAX_PAYLOAD; i++) begin
				if (k == 4'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= sfr_pkg::POS_PAYLOAD + 4'(MAX_PAYLOAD))
		else $error("hunt position beyond last payload byte");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenW'(MAX_PAYLOAD))
		else $error("stored length above buffer size");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (pos_q == sfr_pkg::POS_HDR0) && (sum_q == 8'd0))
		else $error("register write did not restart the hunt");

endmodule

### design/sensor_frame_receiver.sv
// Sensor frame receiver top level: register port, input handshake, result register.
// Depends on sfr_pkg and sfr_parser.
`timescale 1ns / 1ps

// Takes one received byte per transfer on rx_byte and hunts for frames laid out as
// header, header, function, length, payload, checksum (8-bit sum of all earlier
// frame bytes). One byte is taken every cycle that in_ready is high: the hunt position,
// length, running sum and payload store are updated in the same cycle the byte is
// taken, and a frame's result is registered into a single output register as its
// checksum byte is taken. in_ready only drops while that register holds a result
// that the downstream side is not taking. A bad function byte or a length above
// MAX_PAYLOAD restarts the hunt. Registers: header_byte at 0x0 (reset 0x5a),
// function_code at 0x4 (reset 0x45); a write to either restarts the hunt.
module sensor_frame_receiver #(
	parameter int MAX_PAYLOAD = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// frame result
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] payload,
	output logic [2:0]  payload_len,
	output logic        checksum_ok,
	output logic [7:0]  frame_function
);

	logic       [7:0]   header_q;
	logic       [7:0]   function_q;
	logic               cfg_wr;
	logic               in_accept;
	logic               res_valid;
	sfr_pkg::frame_result_t res;
	sfr_pkg::frame_result_t res_q;
	logic               out_valid_q;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= sfr_pkg::HEADER_RESET;
			function_q <= sfr_pkg::FUNCTION_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sfr_pkg::REG_HEADER:   header_q   <= pwdata[7:0];
				sfr_pkg::REG_FUNCTION: function_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			sfr_pkg::REG_HEADER:   prdata = {24'd0, header_q};
			sfr_pkg::REG_FUNCTION: prdata = {24'd0, function_q};
			default: ;
		endcase
	end

	sfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.restart       (cfg_wr),
		.rx_byte       (rx_byte),
		.header_byte   (header_q),
		.function_code (function_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign payload        = res_q.payload;
	assign payload_len    = res_q.payload_len;
	assign checksum_ok    = res_q.checksum_ok;
	assign frame_function = res_q.frame_function;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q)
		else $error("input stalled with empty result register");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && res_valid |=> out_valid_q)
		else $error("frame result dropped");

	a_bad_sum_no_func: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.checksum_ok |-> res_q.frame_function == 8'd0)
		else $error("function reported on a bad checksum");

endmodule
